FILE: rtl/core/clb_pkg.sv
package clb_pkg;

    localparam int NUM_CELLS      = 4096;
    localparam int SLOTS_PER_CELL = 15;
    localparam int INDEX_WIDTH    = 16;
    localparam int CELL_W         = 12;
    localparam int CNT_W          = 4;
    localparam int MEM_DEPTH      = NUM_CELLS * SLOTS_PER_CELL;
    localparam int MEM_AW         = $clog2(MEM_DEPTH);

    localparam logic [1:0] MODE_INSERT  = 2'd0;
    localparam logic [1:0] MODE_READ    = 2'd1;
    localparam logic [1:0] MODE_CLEAR   = 2'd2;
    localparam logic [1:0] MODE_IGNORED = 2'd3;

    localparam logic [2:0] REG_X_ORIGIN = 3'd0;
    localparam logic [2:0] REG_Y_ORIGIN = 3'd1;
    localparam logic [2:0] REG_Z_ORIGIN = 3'd2;
    localparam logic [2:0] REG_X_INV    = 3'd3;
    localparam logic [2:0] REG_Y_INV    = 3'd4;
    localparam logic [2:0] REG_Z_INV    = 3'd5;
    localparam logic [2:0] REG_X_BINS   = 3'd6;
    localparam logic [2:0] REG_Y_BINS   = 3'd7;

    typedef struct packed {
        logic [31:0] x_origin;
        logic [31:0] y_origin;
        logic [31:0] z_origin;
        logic [31:0] x_inv;
        logic [31:0] y_inv;
        logic [31:0] z_inv;
        logic [12:0] x_bins;
        logic [12:0] y_bins;
    } cfg_t;

    typedef struct packed {
        logic [1:0]             mode;
        logic                   oor;
        logic [CELL_W-1:0]      cell_idx;
        logic [INDEX_WIDTH-1:0] pidx;
        logic [3:0]             slot;
    } cmd_t;

    typedef struct packed {
        logic                   full;
        logic                   oor;
        logic [INDEX_WIDTH-1:0] rval;
        logic [CNT_W-1:0]       count;
        logic [3:0]             slot;
        logic [CELL_W-1:0]      cell_idx;
    } res_t;

endpackage

FILE: rtl/core/clb_front.sv
module clb_front (
    input  logic          clk,
    input  logic          rst_n,
    input  clb_pkg::cfg_t cfg,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [1:0]    in_mode,
    input  logic [127:0]  in_data,
    input  logic          q_full,
    output logic          q_push,
    output clb_pkg::cmd_t q_cmd
);
    import clb_pkg::*;

    typedef enum logic [2:0] {F_IDLE, F_DIFF, F_MUL, F_BIN, F_ZY, F_CELL, F_PUSH} fstate_t;

    fstate_t     state_reg;
    cmd_t        cmd_reg;
    logic [31:0] xc_reg, yc_reg, zc_reg;
    logic [32:0] dx_reg, dy_reg, dz_reg;
    logic [63:0] px_reg, py_reg, pz_reg;
    logic        nx_reg, ny_reg, nz_reg;
    logic [12:0] xb_reg, yb_reg;
    logic [CELL_W-1:0] zb_reg;
    logic [25:0] t_reg;
    logic [38:0] c_reg;

    logic okx, oky, okz, cell_ok;

    always_comb
    begin
        okx = !(nx_reg && cfg.x_inv != 32'd0) &&
              (nx_reg ? (cfg.x_bins != 13'd0) : (px_reg[63:16] < 48'(cfg.x_bins)));
        oky = !(ny_reg && cfg.y_inv != 32'd0) &&
              (ny_reg ? (cfg.y_bins != 13'd0) : (py_reg[63:16] < 48'(cfg.y_bins)));
        okz = !(nz_reg && cfg.z_inv != 32'd0) &&
              (nz_reg || (pz_reg[63:16] < 48'(NUM_CELLS)));
        cell_ok = c_reg < 39'(NUM_CELLS);
    end

    assign in_ready = (state_reg == F_IDLE);
    assign q_push   = (state_reg == F_PUSH) && !q_full;

    always_comb
    begin
        q_cmd          = cmd_reg;
        q_cmd.oor      = (cmd_reg.mode != MODE_IGNORED) && (cmd_reg.oor || !cell_ok);
        q_cmd.cell_idx = (cell_ok && cmd_reg.mode != MODE_IGNORED) ? c_reg[CELL_W-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (in_valid)
                    begin
                        xc_reg           <= in_data[31:0];
                        yc_reg           <= in_data[63:32];
                        zc_reg           <= in_data[95:64];
                        cmd_reg.mode     <= in_mode;
                        cmd_reg.pidx     <= in_data[111:96];
                        cmd_reg.slot     <= in_data[127:124];
                        cmd_reg.oor      <= 1'b0;
                        cmd_reg.cell_idx <= '0;
                        c_reg            <= 39'(in_data[123:112]);
                        state_reg        <= (in_mode == MODE_INSERT) ? F_DIFF : F_PUSH;
                    end
                end
                F_DIFF:
                begin
                    dx_reg    <= {xc_reg[31], xc_reg} - {cfg.x_origin[31], cfg.x_origin};
                    dy_reg    <= {yc_reg[31], yc_reg} - {cfg.y_origin[31], cfg.y_origin};
                    dz_reg    <= {zc_reg[31], zc_reg} - {cfg.z_origin[31], cfg.z_origin};
                    state_reg <= F_MUL;
                end
                F_MUL:
                begin
                    px_reg    <= 64'(dx_reg[31:0]) * 64'(cfg.x_inv);
                    py_reg    <= 64'(dy_reg[31:0]) * 64'(cfg.y_inv);
                    pz_reg    <= 64'(dz_reg[31:0]) * 64'(cfg.z_inv);
                    nx_reg    <= dx_reg[32];
                    ny_reg    <= dy_reg[32];
                    nz_reg    <= dz_reg[32];
                    state_reg <= F_BIN;
                end
                F_BIN:
                begin
                    xb_reg      <= nx_reg ? 13'd0 : px_reg[28:16];
                    yb_reg      <= ny_reg ? 13'd0 : py_reg[28:16];
                    zb_reg      <= nz_reg ? '0 : pz_reg[16 +: CELL_W];
                    cmd_reg.oor <= !(okx && oky && okz);
                    state_reg   <= F_ZY;
                end
                F_ZY:
                begin
                    t_reg     <= 26'(zb_reg) * 26'(cfg.y_bins) + 26'(yb_reg);
                    state_reg <= F_CELL;
                end
                F_CELL:
                begin
                    c_reg     <= 39'(t_reg) * 39'(cfg.x_bins) + 39'(xb_reg);
                    state_reg <= F_PUSH;
                end
                F_PUSH:
                begin
                    if (!q_full)
                        state_reg <= F_IDLE;
                end
                default:
                    state_reg <= F_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/core/clb_queue.sv
module clb_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  clb_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output clb_pkg::cmd_t head
);
    import clb_pkg::*;

    cmd_t       slots_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] fill_reg;

    assign full  = (fill_reg == 2'd2);
    assign empty = (fill_reg == 2'd0);
    assign head  = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
            slots_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push && !full)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop && !empty)
                rd_ptr_reg <= !rd_ptr_reg;
            fill_reg <= fill_reg + 2'(push && !full) - 2'(pop && !empty);
        end
    end

endmodule

FILE: rtl/core/clb_back.sv
module clb_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  clb_pkg::cmd_t q_head,
    output logic          q_pop,
    output logic          out_valid,
    input  logic          out_ready,
    output clb_pkg::res_t out_res
);
    import clb_pkg::*;

    typedef enum logic [2:0] {B_CLEAR, B_IDLE, B_RD, B_EXEC, B_MRD} bstate_t;

    bstate_t                state_reg;
    cmd_t                   cur_reg;
    logic [CELL_W-1:0]      clr_reg;
    logic                   out_valid_reg;
    res_t                   out_reg;
    logic [CNT_W-1:0]       cnt_rd_reg;
    logic [INDEX_WIDTH-1:0] mem_rd_reg;

    logic [CNT_W-1:0]       cnt_mem [NUM_CELLS];
    logic [INDEX_WIDTH-1:0] member_mem [MEM_DEPTH];

    logic                   full, is_ins, read_hit;
    logic                   cnt_we, mem_we;
    logic [CELL_W-1:0]      cnt_waddr;
    logic [CNT_W-1:0]       cnt_wdata, cnt_inc;
    logic [MEM_AW-1:0]      mem_waddr, mem_raddr;
    res_t                   res;

    always_comb
    begin
        cnt_inc  = cnt_rd_reg + 1'b1;
        full     = 32'(cnt_rd_reg) >= SLOTS_PER_CELL;
        is_ins   = (cur_reg.mode == MODE_INSERT) && !cur_reg.oor;
        read_hit = (cur_reg.mode == MODE_READ) && !cur_reg.oor && cur_reg.slot != 4'd0 &&
                   cur_reg.slot <= cnt_rd_reg && 32'(cur_reg.slot) <= SLOTS_PER_CELL;
        cnt_we   = (state_reg == B_CLEAR) ||
                   (state_reg == B_EXEC && ((is_ins && !full) ||
                    (cur_reg.mode == MODE_CLEAR && !cur_reg.oor)));
        cnt_waddr = (state_reg == B_CLEAR) ? clr_reg : cur_reg.cell_idx;
        cnt_wdata = (state_reg == B_EXEC && is_ins) ? cnt_inc : '0;
        mem_we    = (state_reg == B_EXEC) && is_ins && !full;
        mem_waddr = MEM_AW'(cnt_rd_reg) * MEM_AW'(NUM_CELLS) + MEM_AW'(cur_reg.cell_idx);
        mem_raddr = MEM_AW'(cur_reg.slot - 4'd1) * MEM_AW'(NUM_CELLS) +
                    MEM_AW'(cur_reg.cell_idx);

        res = '0;
        if (cur_reg.mode == MODE_IGNORED)
            res = '0;
        else if (cur_reg.oor)
            res.oor = 1'b1;
        else
        begin
            res.cell_idx = cur_reg.cell_idx;
            case (cur_reg.mode)
                MODE_INSERT:
                begin
                    res.full  = full;
                    res.slot  = full ? 4'd0 : 4'(cnt_inc);
                    res.count = full ? cnt_rd_reg : cnt_inc;
                end
                MODE_READ:
                    res.count = cnt_rd_reg;
                default:
                    res.count = '0;
            endcase
        end
    end

    assign q_pop     = (state_reg == B_IDLE) && !q_empty && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

    always_ff @(posedge clk)
    begin
        if (cnt_we)
            cnt_mem[cnt_waddr] <= cnt_wdata;
        cnt_rd_reg <= cnt_mem[cur_reg.cell_idx];
        if (mem_we)
            member_mem[mem_waddr] <= cur_reg.pidx;
        mem_rd_reg <= member_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                B_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (32'(clr_reg) == NUM_CELLS - 1)
                        state_reg <= B_IDLE;
                end
                B_IDLE:
                begin
                    if (q_pop)
                    begin
                        cur_reg   <= q_head;
                        state_reg <= B_RD;
                    end
                end
                B_RD:
                    state_reg <= B_EXEC;
                B_EXEC:
                begin
                    out_reg <= res;
                    if (read_hit)
                        state_reg <= B_MRD;
                    else
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= B_IDLE;
                    end
                end
                B_MRD:
                begin
                    out_reg.rval  <= mem_rd_reg;
                    out_valid_reg <= 1'b1;
                    state_reg     <= B_IDLE;
                end
                default:
                    state_reg <= B_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/core/cell_list_binning_3d.sv
// Channel   Direction  Handshake           Payload
// s_*       in         s_tvalid/s_tready   s_tuser mode, s_tdata coordinates and selects
// m_*       out        m_tvalid/m_tready   m_tdata cell, slot, count, value, flags
// cfg_*     in         cfg_we              cfg_index, cfg_wdata
//
// An insert passes the binning front end through its difference, multiply, bin, ZY
// and cell states, which multiply the three axes in parallel and then form the cell
// index in two multiply steps; read and clear items go straight to the push state.
// The back end does the count read-modify-write and, on a read hit, the member read.
// After reset the count memory is cleared cell by cell; items are queued meanwhile.
// A two-entry queue and the output register let either side stall independently.
module cell_list_binning_3d (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,  // x_coord, y_coord, z_coord, point_index, cell_select,
                                   // slot_select
    input  logic [1:0]   s_tuser,  // mode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [39:0]  m_tdata,  // cell_index, member_slot, member_count, read_value,
                                   // out_of_range, cell_full, zero fill
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_wdata
);
    import clb_pkg::*;

    cfg_t cfg_reg;
    cmd_t push_cmd, head_cmd;
    res_t res;
    logic q_push, q_full, q_pop, q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_origin <= 32'd0;
            cfg_reg.y_origin <= 32'd0;
            cfg_reg.z_origin <= 32'd0;
            cfg_reg.x_inv    <= 32'd65536;
            cfg_reg.y_inv    <= 32'd65536;
            cfg_reg.z_inv    <= 32'd65536;
            cfg_reg.x_bins   <= 13'd16;
            cfg_reg.y_bins   <= 13'd16;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_X_ORIGIN: cfg_reg.x_origin <= cfg_wdata;
                REG_Y_ORIGIN: cfg_reg.y_origin <= cfg_wdata;
                REG_Z_ORIGIN: cfg_reg.z_origin <= cfg_wdata;
                REG_X_INV:    cfg_reg.x_inv    <= cfg_wdata;
                REG_Y_INV:    cfg_reg.y_inv    <= cfg_wdata;
                REG_Z_INV:    cfg_reg.z_inv    <= cfg_wdata;
                REG_X_BINS:   cfg_reg.x_bins   <= cfg_wdata[12:0];
                REG_Y_BINS:   cfg_reg.y_bins   <= cfg_wdata[12:0];
                default:      cfg_reg.y_bins   <= cfg_reg.y_bins;
            endcase
        end
    end

    clb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_mode  (s_tuser),
        .in_data  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    clb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (head_cmd)
    );

    clb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (head_cmd),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {2'b00, res};

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[37] |-> m_tdata[15:12] == 4'd0)
        else $error("full cell reported a written slot");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[36] |-> m_tdata[11:0] == 12'd0 && m_tdata[19:16] == 4'd0)
        else $error("out of range result carries cell data");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[15:12] != 4'd0 |-> m_tdata[15:12] == m_tdata[19:16])
        else $error("inserted slot differs from new count");

endmodule

FILE: tb/cell_list_binning_3d_tb.sv
module cell_list_binning_3d_tb;
    import clb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]  mode;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [15:0] pidx;
        logic [11:0] sel;
        logic [3:0]  slot;
    } point_op_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [39:0]  m_tdata;
    logic         cfg_we;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_wdata;

    cell_list_binning_3d dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    cfg_t        bin_cfg;
    logic [3:0]  count_model [NUM_CELLS];
    logic [15:0] member_model [SLOTS_PER_CELL][NUM_CELLS];

    point_op_t   pending_ops[$];
    res_t        expected_results[$];
    logic [11:0] recent_cells[$];
    point_op_t   cur_op;

    int  gap_max;
    int  stall_max;
    int  burst_left;
    int  gap_left;
    int  stall_left;
    int  errors;
    int  cycles;
    int  n_insert;
    int  n_read;
    int  n_clear;
    int  n_oor;
    int  n_full;

    localparam int CYCLE_LIMIT = 400000;

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic logic axis_bin(input logic [31:0] coord, input logic [31:0] origin,
                                      input logic [31:0] inv, output logic [63:0] bin);
        logic signed [33:0] diff;
        logic [63:0]        prod;
        diff = $signed({{2{coord[31]}}, coord}) - $signed({{2{origin[31]}}, origin});
        bin  = '0;
        if (diff < 0)
            return (inv == 0);
        prod = 64'(diff[32:0]) * 64'(inv);
        bin  = prod >> 16;
        return 1'b1;
    endfunction

    function automatic logic locate_cell(input point_op_t op, output logic [11:0] cell_out);
        logic [63:0] xb;
        logic [63:0] yb;
        logic [63:0] zb;
        logic [63:0] full_cell;
        logic        ok;
        ok = axis_bin(op.x, bin_cfg.x_origin, bin_cfg.x_inv, xb);
        ok = axis_bin(op.y, bin_cfg.y_origin, bin_cfg.y_inv, yb) && ok;
        ok = axis_bin(op.z, bin_cfg.z_origin, bin_cfg.z_inv, zb) && ok;
        cell_out = '0;
        if (!ok || xb >= bin_cfg.x_bins || yb >= bin_cfg.y_bins || zb >= NUM_CELLS)
            return 1'b0;
        full_cell = (zb * bin_cfg.y_bins + yb) * bin_cfg.x_bins + xb;
        if (full_cell >= NUM_CELLS)
            return 1'b0;
        cell_out = full_cell[11:0];
        return 1'b1;
    endfunction

    function automatic res_t bin_point(input point_op_t op);
        res_t        r;
        logic [11:0] cell_no;
        r = '0;
        if (op.mode == MODE_INSERT) begin
            if (!locate_cell(op, cell_no)) begin
                r.oor = 1'b1;
            end else begin
                r.cell_idx = cell_no;
                r.count    = count_model[cell_no];
                if (count_model[cell_no] >= SLOTS_PER_CELL) begin
                    r.full = 1'b1;
                end else begin
                    r.count = 4'(count_model[cell_no] + 1);
                    r.slot  = r.count;
                    count_model[cell_no] = r.count;
                    member_model[r.count - 1][cell_no] = op.pidx;
                end
            end
        end else if (op.mode == MODE_CLEAR) begin
            r.cell_idx = op.sel;
            count_model[op.sel] = '0;
        end else if (op.mode == MODE_READ) begin
            r.cell_idx = op.sel;
            r.count    = count_model[op.sel];
            if (op.slot >= 1 && op.slot <= count_model[op.sel])
                r.rval = member_model[op.slot - 1][op.sel];
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tuser    <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            if (s_tvalid && s_tready)
                expected_results.push_back(bin_point(cur_op));
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_ops.size() > 0) begin
                    cur_op   = pending_ops.pop_front();
                    s_tdata  <= {cur_op.slot, cur_op.sel, cur_op.pidx,
                                 cur_op.z, cur_op.y, cur_op.x};
                    s_tuser  <= cur_op.mode;
                    s_tvalid <= 1'b1;
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left   <= (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    function automatic void report_field(input string name, input logic [15:0] want,
                                         input logic [15:0] got);
        if (want !== got) begin
            $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        res_t got;
        if (!rst_n) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
            cycles     <= 0;
        end else begin
            cycles <= cycles + 1;
            if (cycles > CYCLE_LIMIT) begin
                $display("Timeout after %0d cycles", cycles);
                $display("Mismatches found");
                $finish;
            end
            if (m_tvalid && m_tready) begin
                got = res_t'(m_tdata[37:0]);
                if (expected_results.size() == 0) begin
                    $display("%0t ns: unexpected result %0h", $time, m_tdata);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    report_field("cell_index", 16'(want.cell_idx), 16'(got.cell_idx));
                    report_field("member_slot", 16'(want.slot), 16'(got.slot));
                    report_field("member_count", 16'(want.count), 16'(got.count));
                    report_field("read_value", want.rval, got.rval);
                    report_field("out_of_range", 16'(want.oor), 16'(got.oor));
                    report_field("cell_full", 16'(want.full), 16'(got.full));
                    report_field("zero fill", 16'(2'b00), 16'(m_tdata[39:38]));
                    n_oor  += want.oor;
                    n_full += want.full;
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_tready   <= 1'b0;
            end else if (stall_max > 0 && $urandom_range(0, 5) == 0) begin
                stall_left <= $urandom_range(1, stall_max);
                m_tready   <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_X_ORIGIN: bin_cfg.x_origin = val;
            REG_Y_ORIGIN: bin_cfg.y_origin = val;
            REG_Z_ORIGIN: bin_cfg.z_origin = val;
            REG_X_INV:    bin_cfg.x_inv    = val;
            REG_Y_INV:    bin_cfg.y_inv    = val;
            REG_Z_INV:    bin_cfg.z_inv    = val;
            REG_X_BINS:   bin_cfg.x_bins   = val[12:0];
            default:      bin_cfg.y_bins   = val[12:0];
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic setup_bins(input logic [31:0] xo, input logic [31:0] yo,
                              input logic [31:0] zo, input logic [31:0] inv,
                              input logic [12:0] xn, input logic [12:0] yn);
        write_reg(REG_X_ORIGIN, xo);
        write_reg(REG_Y_ORIGIN, yo);
        write_reg(REG_Z_ORIGIN, zo);
        write_reg(REG_X_INV, inv);
        write_reg(REG_Y_INV, inv);
        write_reg(REG_Z_INV, inv);
        write_reg(REG_X_BINS, 32'(xn));
        write_reg(REG_Y_BINS, 32'(yn));
    endtask

    task automatic queue_op(input logic [1:0] mode, input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z, input logic [15:0] pidx,
                            input logic [11:0] sel, input logic [3:0] slot);
        point_op_t   op;
        logic [11:0] cell_no;
        op = '{mode, x, y, z, pidx, sel, slot};
        if (mode == MODE_INSERT) begin
            n_insert++;
            if (locate_cell(op, cell_no))
                recent_cells.push_back(cell_no);
            if (recent_cells.size() > 8)
                void'(recent_cells.pop_front());
        end else if (mode == MODE_READ) begin
            n_read++;
        end else begin
            n_clear++;
        end
        pending_ops.push_back(op);
    endtask

    function automatic logic [31:0] pick_coord(input logic [31:0] origin, input int span);
        if ($urandom_range(0, 4) == 0)
            return $urandom;
        return origin + $urandom_range(0, span);
    endfunction

    function automatic logic [11:0] pick_cell();
        if (recent_cells.size() > 0 && $urandom_range(0, 3) != 0)
            return recent_cells[$urandom_range(0, recent_cells.size() - 1)];
        return 12'($urandom);
    endfunction

    task automatic random_ops(input int n, input int span);
        int kind;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(0, 99);
            if (kind < 60)
                queue_op(MODE_INSERT, pick_coord(bin_cfg.x_origin, span),
                         pick_coord(bin_cfg.y_origin, span),
                         pick_coord(bin_cfg.z_origin, span), 16'($urandom), 12'($urandom),
                         4'($urandom));
            else if (kind < 88)
                queue_op(MODE_READ, $urandom, $urandom, $urandom, 16'($urandom), pick_cell(),
                         4'($urandom_range(1, 15)));
            else
                queue_op(MODE_CLEAR, $urandom, $urandom, $urandom, 16'($urandom), pick_cell(),
                         4'($urandom_range(1, 15)));
        end
    endtask

    task automatic wait_idle();
        while (pending_ops.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic pick_idling(input logic none);
        gap_max   = none ? 0 : $urandom_range(0, 8);
        stall_max = none ? 0 : $urandom_range(0, 10);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        errors    = 0;
        n_insert  = 0;
        n_read    = 0;
        n_clear   = 0;
        n_oor     = 0;
        n_full    = 0;
        gap_max   = 3;
        stall_max = 4;
        bin_cfg   = '{32'd0, 32'd0, 32'd0, 32'h10000, 32'h10000, 32'h10000, 13'd16, 13'd16};
        for (int c = 0; c < NUM_CELLS; c++)
            count_model[c] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        queue_op(MODE_INSERT, 32'd0, 32'd0, 32'd0, 16'h0000, 12'd0, 4'd1);
        queue_op(MODE_INSERT, 32'h8000_0000, 32'd0, 32'd0, 16'hFFFF, 12'd0, 4'd1);
        queue_op(MODE_INSERT, 32'h7FFF_FFFF, 32'd0, 32'd0, 16'h1234, 12'd0, 4'd1);
        queue_op(MODE_INSERT, 32'h000F_FFFF, 32'h000F_FFFF, 32'h000F_FFFF, 16'hA5A5,
                 12'd0, 4'd1);
        queue_op(MODE_INSERT, 32'h0010_0000, 32'd0, 32'd0, 16'h5A5A, 12'd0, 4'd1);
        queue_op(MODE_INSERT, 32'd0, 32'd0, 32'h0010_0000, 16'h0001, 12'd0, 4'd1);
        queue_op(MODE_READ, 32'd0, 32'd0, 32'd0, 16'd0, 12'd0, 4'd1);
        queue_op(MODE_READ, 32'd0, 32'd0, 32'd0, 16'd0, 12'd0, 4'd2);
        queue_op(MODE_READ, 32'd0, 32'd0, 32'd0, 16'd0, 12'd4095, 4'd15);
        queue_op(MODE_CLEAR, 32'd0, 32'd0, 32'd0, 16'd0, 12'd0, 4'd1);
        queue_op(MODE_READ, 32'd0, 32'd0, 32'd0, 16'd0, 12'd0, 4'd1);
        for (int i = 0; i < 16; i++)
            queue_op(MODE_INSERT, 32'h0005_8000, 32'd0, 32'd0, 16'(i * 4099), 12'd0, 4'd1);
        queue_op(MODE_READ, 32'd0, 32'd0, 32'd0, 16'd0, 12'd5, 4'd15);
        wait_idle();

        setup_bins($urandom_range(0, 32'h00FF_FFFF), 32'hFFF0_0000, 32'h0001_2345,
                   32'h0001_0000, 13'd4, 13'd4);
        pick_idling(1'b0);
        random_ops(120, 5 << 16);
        wait_idle();

        setup_bins(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd0, 13'd4096, 13'd1);
        pick_idling(1'b0);
        random_ops(100, 32'h7FFF_FFFF);
        wait_idle();

        setup_bins(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                   13'd4096, 13'd4096);
        pick_idling(1'b1);
        random_ops(80, 0);
        wait_idle();

        setup_bins(32'd0, 32'd0, 32'd0, 32'h0000_8000, 13'd1, 13'd1);
        pick_idling(1'b0);
        random_ops(100, 3 << 16);
        wait_idle();

        setup_bins($urandom, $urandom, $urandom, 32'h0002_0000, 13'd8, 13'd8);
        pick_idling(1'b0);
        random_ops(120, 6 << 16);
        wait_idle();

        $display("Covered %0d inserts, %0d reads and %0d clears over six bin settings.",
                 n_insert, n_read, n_clear);
        $display("Results flagged out of range: %0d, full cell: %0d.", n_oor, n_full);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
